[rtl/pcan_pkg.sv]
// Shared constants, payload types and item classes of the path canonicalizer.
`default_nettype none
package pcan_pkg;

	// Sizes: output buffer capacity is clamped so a path fits into 16 words
	localparam int OUT_SIZE  = 128;
	localparam int JOIN_SIZE = 128;
	localparam int CAP       = (OUT_SIZE > 129) ? 129 : OUT_SIZE;
	localparam int LEN_W     = ($clog2(CAP) < 4) ? 4 : $clog2(CAP);
	localparam int ROW_W     = LEN_W - 3;
	localparam int ROWS      = (CAP + 7) / 8;
	localparam int JOIN_W    = $clog2(JOIN_SIZE);

	// Queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	localparam logic [7:0] CHAR_SLASH = 8'h2F;
	localparam logic [7:0] CHAR_DOT   = 8'h2E;

	// Item class decided by the front
	typedef enum logic [1:0] {
		CLS_NONE  = 2'd0,
		CLS_SLASH = 2'd1,
		CLS_DOT   = 2'd2,
		CLS_CHAR  = 2'd3
	} cls_t;

	typedef struct packed {
		logic [7:0] path_byte;
		logic       final_byte;
	} in_t;

	typedef struct packed {
		logic [63:0] out_word;
		logic [3:0]  out_count;
		logic        out_last;
		logic        path_error;
	} out_t;

	typedef struct packed {
		cls_t       cls;
		logic [7:0] ch;
		logic       fin;
	} op_t;

	typedef struct packed {
		logic not_empty;
		logic not_full;
	} q_stat_t;

endpackage
`default_nettype wire

[rtl/pcan_front.sv]
// Front end: accepts input items, applies the join limit and classifies each byte.
`default_nettype none
module pcan_front (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     item_valid,
	output logic                    item_ready,
	input  pcan_pkg::in_t           item,
	input  pcan_pkg::q_stat_t       q_stat,
	output logic                    push,
	output pcan_pkg::op_t           push_op
);

	logic [pcan_pkg::JOIN_W-1:0] joined_q;
	logic accept;
	logic take;

	assign item_ready = q_stat.not_full;
	assign accept     = item_valid && item_ready;
	assign take       = (item.path_byte != 8'd0) &&
		(joined_q < pcan_pkg::JOIN_W'(pcan_pkg::JOIN_SIZE - 1));

	// Only items that change state or end a path go to the back end
	assign push = accept && (take || item.final_byte);

	// Classify
	always_comb begin
		push_op.ch  = item.path_byte;
		push_op.fin = item.final_byte;
		if (!take) begin
			push_op.cls = pcan_pkg::CLS_NONE;
		end else if (item.path_byte == pcan_pkg::CHAR_SLASH) begin
			push_op.cls = pcan_pkg::CLS_SLASH;
		end else if (item.path_byte == pcan_pkg::CHAR_DOT) begin
			push_op.cls = pcan_pkg::CLS_DOT;
		end else begin
			push_op.cls = pcan_pkg::CLS_CHAR;
		end
	end

	// Joined byte count, restarts after the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			joined_q <= '0;
		end else if (accept) begin
			if (item.final_byte) begin
				joined_q <= '0;
			end else if (take) begin
				joined_q <= joined_q + pcan_pkg::JOIN_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

[rtl/pcan_fifo.sv]
// Short queue of classified items between the front and back ends.
`default_nettype none
module pcan_fifo (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     push,
	input  pcan_pkg::op_t           push_op,
	input  wire                     pop,
	output pcan_pkg::op_t           pop_op,
	output pcan_pkg::q_stat_t       q_stat
);

	pcan_pkg::op_t q_mem_q [pcan_pkg::QDEPTH];
	logic [pcan_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [pcan_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [pcan_pkg::QCNT_W-1:0] cnt_q;

	assign pop_op           = q_mem_q[rd_ptr_q];
	assign q_stat.not_empty = (cnt_q != '0);
	assign q_stat.not_full  = (cnt_q != pcan_pkg::QCNT_W'(pcan_pkg::QDEPTH));

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= push_op;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + pcan_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + pcan_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + pcan_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - pcan_pkg::QCNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

[rtl/pcan_back.sv]
// Back end: component tracking, canonical buffer, dot-dot rollback and word emission.
`default_nettype none
module pcan_back (
	input  wire                     clk,
	input  wire                     arst_n,
	input  pcan_pkg::q_stat_t       q_stat,
	input  pcan_pkg::op_t           pop_op,
	output logic                    pop,
	output logic                    result_valid,
	input  wire                     result_ready,
	output pcan_pkg::out_t          result
);

	localparam int LW = pcan_pkg::LEN_W;
	localparam int RW = pcan_pkg::ROW_W;

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_APP    = 7'b0000010,
		S_ENDC   = 7'b0000100,
		S_RB_RD  = 7'b0001000,
		S_RB_CHK = 7'b0010000,
		S_EMIT   = 7'b0100000,
		S_WORD   = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	// Path state
	logic [LW-1:0] canon_len_q, canon_len_d;
	logic          last_slash_q, last_slash_d;
	logic          plain_q, plain_d;
	logic [1:0]    dots_q, dots_d;
	logic          ovf_q, ovf_d;
	logic          fin_q, fin_d;

	// Pending appends of one item
	logic          app_slash_q, app_slash_d;
	logic [1:0]    app_dots_q, app_dots_d;
	logic [7:0]    app_char_q, app_char_d;
	logic [7:0]    app_b;

	// Emission
	logic [LW-1:0] rem_q, rem_d;
	logic [RW-1:0] word_q, word_d;

	// Buffer memory, one row of eight bytes per entry
	logic [63:0]   canon_buf_q [pcan_pkg::ROWS];
	logic [63:0]   rd_row_q;
	logic          rd_en;
	logic [RW-1:0] rd_idx;
	logic          wr_en;

	// Output register
	pcan_pkg::out_t result_q, res_d;
	logic           result_valid_q;
	logic           res_load;
	logic           slot_free;

	logic [LW-1:0] lenm1;
	logic [LW-1:0] len1;
	logic [LW-1:0] elen;
	logic          found;
	logic [2:0]    k_sel;
	logic [3:0]    cnt;
	logic [63:0]   word_bytes;
	state_t        post;

	assign result       = result_q;
	assign result_valid = result_valid_q;
	assign slot_free    = !result_valid_q || result_ready;
	assign lenm1        = canon_len_q - LW'(1);
	assign len1         = last_slash_q ? lenm1 : canon_len_q;
	assign elen         = (last_slash_q && canon_len_q > LW'(1)) ? lenm1 : canon_len_q;
	assign post         = fin_q ? S_EMIT : S_IDLE;

	// Next byte to append: separator, held dots, then the character
	always_comb begin
		if (app_slash_q) begin
			app_b = pcan_pkg::CHAR_SLASH;
		end else if (app_dots_q != 2'd0) begin
			app_b = pcan_pkg::CHAR_DOT;
		end else begin
			app_b = app_char_q;
		end
	end

	// Rollback scan: highest slash at or below the last byte within the read row
	always_comb begin
		found = 1'b0;
		k_sel = 3'd0;
		for (int k = 0; k < 8; k++) begin
			if (3'(k) <= lenm1[2:0] &&
				(rd_row_q[8*k +: 8] == pcan_pkg::CHAR_SLASH ||
				(k == 0 && lenm1[LW-1:3] == '0))) begin
				found = 1'b1;
				k_sel = 3'(k);
			end
		end
	end

	// Output word from the read row; entry 0 is always the root slash
	assign cnt = (rem_q > LW'(8)) ? 4'd8 : rem_q[3:0];
	always_comb begin
		for (int k = 0; k < 8; k++) begin
			if (4'(k) >= cnt) begin
				word_bytes[8*k +: 8] = 8'd0;
			end else if (k == 0 && word_q == '0) begin
				word_bytes[8*k +: 8] = pcan_pkg::CHAR_SLASH;
			end else begin
				word_bytes[8*k +: 8] = rd_row_q[8*k +: 8];
			end
		end
	end

	// Sequencer
	always_comb begin
		state_d      = state_q;
		canon_len_d  = canon_len_q;
		last_slash_d = last_slash_q;
		plain_d      = plain_q;
		dots_d       = dots_q;
		ovf_d        = ovf_q;
		fin_d        = fin_q;
		app_slash_d  = app_slash_q;
		app_dots_d   = app_dots_q;
		app_char_d   = app_char_q;
		rem_d        = rem_q;
		word_d       = word_q;
		pop          = 1'b0;
		wr_en        = 1'b0;
		rd_en        = 1'b0;
		rd_idx       = '0;
		res_load     = 1'b0;
		res_d        = result_q;
		case (state_q)
			S_IDLE: begin
				if (q_stat.not_empty) begin
					pop   = 1'b1;
					fin_d = pop_op.fin;
					if (ovf_q || pop_op.cls == pcan_pkg::CLS_NONE) begin
						state_d = pop_op.fin ? S_ENDC : S_IDLE;
					end else if (pop_op.cls == pcan_pkg::CLS_SLASH) begin
						state_d = S_ENDC;
					end else if (pop_op.cls == pcan_pkg::CLS_DOT && !plain_q &&
						dots_q != 2'd2) begin
						// hold the dot until the component proves not to be . or ..
						dots_d  = dots_q + 2'd1;
						state_d = pop_op.fin ? S_ENDC : S_IDLE;
					end else begin
						app_slash_d = !plain_q && !last_slash_q;
						app_dots_d  = plain_q ? 2'd0 : dots_q;
						app_char_d  = pop_op.ch;
						plain_d     = 1'b1;
						dots_d      = 2'd0;
						state_d     = S_APP;
					end
				end
			end
			S_APP: begin
				if (!ovf_q) begin
					if (canon_len_q >= LW'(pcan_pkg::CAP - 1)) begin
						ovf_d = 1'b1;
					end else begin
						wr_en        = 1'b1;
						canon_len_d  = canon_len_q + LW'(1);
						last_slash_d = (app_b == pcan_pkg::CHAR_SLASH);
					end
				end
				if (app_slash_q) begin
					app_slash_d = 1'b0;
				end else if (app_dots_q != 2'd0) begin
					app_dots_d = app_dots_q - 2'd1;
				end else begin
					state_d = fin_q ? S_ENDC : S_IDLE;
				end
			end
			S_ENDC: begin
				if (ovf_q) begin
					state_d = S_EMIT;
				end else begin
					plain_d = 1'b0;
					dots_d  = 2'd0;
					state_d = post;
					// dot-dot: drop trailing slash, then walk back to the previous one
					if (!plain_q && dots_q == 2'd2 && canon_len_q > LW'(1)) begin
						canon_len_d = len1;
						if (len1 > LW'(1)) begin
							state_d = S_RB_RD;
						end else begin
							last_slash_d = 1'b1;
						end
					end
				end
			end
			S_RB_RD: begin
				rd_en   = 1'b1;
				rd_idx  = lenm1[LW-1:3];
				state_d = S_RB_CHK;
			end
			S_RB_CHK: begin
				if (found) begin
					canon_len_d  = {lenm1[LW-1:3], k_sel} + LW'(1);
					last_slash_d = 1'b1;
					state_d      = post;
				end else begin
					canon_len_d = {lenm1[LW-1:3], 3'b000};
					state_d     = S_RB_RD;
				end
			end
			S_EMIT: begin
				if (ovf_q) begin
					if (slot_free) begin
						res_load         = 1'b1;
						res_d.out_word   = '0;
						res_d.out_count  = 4'd0;
						res_d.out_last   = 1'b1;
						res_d.path_error = 1'b1;
						canon_len_d      = LW'(1);
						last_slash_d     = 1'b1;
						plain_d          = 1'b0;
						dots_d           = 2'd0;
						ovf_d            = 1'b0;
						state_d          = S_IDLE;
					end
				end else begin
					rem_d   = elen;
					word_d  = '0;
					rd_en   = 1'b1;
					rd_idx  = '0;
					state_d = S_WORD;
				end
			end
			S_WORD: begin
				if (slot_free) begin
					res_load         = 1'b1;
					res_d.out_word   = word_bytes;
					res_d.out_count  = cnt;
					res_d.out_last   = (rem_q <= LW'(8));
					res_d.path_error = 1'b0;
					if (rem_q <= LW'(8)) begin
						canon_len_d  = LW'(1);
						last_slash_d = 1'b1;
						plain_d      = 1'b0;
						dots_d       = 2'd0;
						ovf_d        = 1'b0;
						state_d      = S_IDLE;
					end else begin
						rem_d  = rem_q - LW'(8);
						word_d = word_q + RW'(1);
						rd_en  = 1'b1;
						rd_idx = word_q + RW'(1);
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Buffer memory with registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			canon_buf_q[canon_len_q[LW-1:3]][{canon_len_q[2:0], 3'b000} +: 8] <= app_b;
		end
		if (rd_en) begin
			rd_row_q <= canon_buf_q[rd_idx];
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (res_load) begin
			result_q <= res_d;
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			canon_len_q    <= LW'(1);
			last_slash_q   <= 1'b1;
			plain_q        <= 1'b0;
			dots_q         <= 2'd0;
			ovf_q          <= 1'b0;
			fin_q          <= 1'b0;
			app_slash_q    <= 1'b0;
			app_dots_q     <= 2'd0;
			app_char_q     <= 8'd0;
			rem_q          <= '0;
			word_q         <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q      <= state_d;
			canon_len_q  <= canon_len_d;
			last_slash_q <= last_slash_d;
			plain_q      <= plain_d;
			dots_q       <= dots_d;
			ovf_q        <= ovf_d;
			fin_q        <= fin_d;
			app_slash_q  <= app_slash_d;
			app_dots_q   <= app_dots_d;
			app_char_q   <= app_char_d;
			rem_q        <= rem_d;
			word_q       <= word_d;
			if (res_load) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

[rtl/path_canonicalizer_unit.sv]
// Path canonicalizer top level: front end, 4-entry item queue and back end.
// Back end per item: pop, then append each byte in turn (separator, held dots, character),
// close a component ('/' or final item), and read and check each buffer row walked back on '..'.
// A final item then emits its path as 8-byte words, or one error result; each result is held
// until the receiver has room for it.
// Reset (arst_n low, asynchronous) returns the path to root and empties the queue.
`default_nettype none
module path_canonicalizer_unit (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     item_valid,
	output logic                    item_ready,
	input  pcan_pkg::in_t           item,
	output logic                    result_valid,
	input  wire                     result_ready,
	output pcan_pkg::out_t          result
);

	pcan_pkg::q_stat_t q_stat;
	pcan_pkg::op_t     push_op;
	pcan_pkg::op_t     pop_op;
	logic              push;
	logic              pop;

	pcan_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.q_stat     (q_stat),
		.push       (push),
		.push_op    (push_op)
	);

	pcan_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.pop     (pop),
		.pop_op  (pop_op),
		.q_stat  (q_stat)
	);

	pcan_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_stat       (q_stat),
		.pop_op       (pop_op),
		.pop          (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule
`default_nettype wire

[test/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the path canonicalizer: random paths, stalls, scoreboard.
module tb;

	localparam int HOLD_LEN    = 300;
	localparam int DRAIN_WAIT  = 200;
	localparam int PHASE_ITEMS = 8;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_ready;
	pcan_pkg::in_t item = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	pcan_pkg::out_t result;

	// Stimulus and scoreboard storage
	pcan_pkg::in_t pending_items [$];
	pcan_pkg::out_t expected_words [$];
	logic [7:0] path_buf [$];

	// Traffic knobs, percent of cycles
	int idle_pct = 0;
	int stall_pct = 0;
	logic hold_go = 1'b0;
	logic hold_done = 1'b0;
	int hold_count = 0;
	logic in_fire = 1'b0;

	// Shadow of the canonical path state
	logic [7:0] canon_buf [pcan_pkg::CAP];
	logic [pcan_pkg::LEN_W-1:0] canon_len;
	logic [6:0] comp_len;
	logic [1:0] comp_dots;
	logic [pcan_pkg::JOIN_W-1:0] joined_cnt;
	logic overflow;

	int unsigned mismatches = 0;
	int unsigned items_queued = 0;
	int unsigned paths_done = 0;
	int unsigned words_checked = 0;
	int unsigned error_results = 0;
	int unsigned rollbacks = 0;
	int unsigned past_join = 0;

	path_canonicalizer_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Canonical path predictor
	task automatic path_restart;
		canon_buf[0] = pcan_pkg::CHAR_SLASH;
		canon_len = pcan_pkg::LEN_W'(1);
		comp_len = '0;
		comp_dots = '0;
		joined_cnt = '0;
		overflow = 1'b0;
	endtask

	task automatic append_byte(input logic [7:0] c);
		if (overflow)
			return;
		if (canon_len >= pcan_pkg::CAP - 1) begin
			overflow = 1'b1;
			return;
		end
		canon_buf[canon_len] = c;
		canon_len++;
	endtask

	// A ".." component walks back to the previous slash, never above root
	task automatic close_component;
		if (comp_len == 2 && comp_dots == 2) begin
			rollbacks++;
			if (canon_len > 1) begin
				if (canon_buf[canon_len - 1] == pcan_pkg::CHAR_SLASH)
					canon_len--;
				while (canon_len > 1 && canon_buf[canon_len - 1] != pcan_pkg::CHAR_SLASH)
					canon_len--;
			end
		end
		comp_len = '0;
		comp_dots = '0;
	endtask

	task automatic take_char(input logic [7:0] c);
		int i;
		if (c == pcan_pkg::CHAR_SLASH) begin
			close_component();
			return;
		end
		// leading dots are held back until the component is known to be a name
		if (c == pcan_pkg::CHAR_DOT && comp_len == comp_dots && comp_dots < 2) begin
			comp_dots++;
			comp_len++;
			return;
		end
		if (comp_len == comp_dots) begin
			if (canon_len > 1 && canon_buf[canon_len - 1] != pcan_pkg::CHAR_SLASH)
				append_byte(pcan_pkg::CHAR_SLASH);
			for (i = 0; i < comp_dots; i++)
				append_byte(pcan_pkg::CHAR_DOT);
			comp_dots = '0;
		end
		append_byte(c);
		if (comp_len < 127)
			comp_len++;
	endtask

	task automatic predict_item(input pcan_pkg::in_t it);
		pcan_pkg::out_t w;
		int len;
		int pos;
		int cnt;
		int k;
		if (it.path_byte != 8'h00) begin
			if (joined_cnt < pcan_pkg::JOIN_SIZE - 1) begin
				joined_cnt++;
				if (!overflow)
					take_char(it.path_byte);
			end else begin
				past_join++;
			end
		end
		if (!it.final_byte)
			return;
		paths_done++;
		if (!overflow)
			close_component();
		if (overflow) begin
			w = '0;
			w.out_last = 1'b1;
			w.path_error = 1'b1;
			expected_words.push_back(w);
			error_results++;
			path_restart();
			return;
		end
		// emit without trailing slash, eight characters per word
		len = canon_len;
		if (len > 1 && canon_buf[len - 1] == pcan_pkg::CHAR_SLASH)
			len--;
		pos = 0;
		while (pos < len) begin
			w = '0;
			cnt = (len - pos > 8) ? 8 : len - pos;
			for (k = 0; k < cnt; k++)
				w.out_word[8*k +: 8] = canon_buf[pos + k];
			pos += cnt;
			w.out_count = 4'(cnt);
			w.out_last = (pos >= len);
			expected_words.push_back(w);
		end
		path_restart();
	endtask

	function automatic void check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endfunction

	// Scoreboard: results against the oldest expected word, then predict accepted items
	always @(posedge clk) begin
		pcan_pkg::out_t want;
		in_fire <= item_valid && item_ready;
		if (arst_n) begin
			if (result_valid && result_ready) begin
				if (expected_words.size() == 0) begin
					$error("result with nothing expected: %h", result);
					mismatches++;
				end else begin
					want = expected_words.pop_front();
					check_field("out_word", want.out_word, result.out_word);
					check_field("out_count", want.out_count, result.out_count);
					check_field("out_last", want.out_last, result.out_last);
					check_field("path_error", want.path_error, result.path_error);
					words_checked++;
				end
			end
			if (item_valid && item_ready)
				predict_item(item);
		end
	end

	// Driver: offers queued items with random gaps
	always @(negedge clk) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else if (!item_valid || in_fire) begin
			if (pending_items.size() != 0 && $urandom_range(99) >= idle_pct) begin
				item <= pending_items.pop_front();
				item_valid <= 1'b1;
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off on request
	always @(negedge clk) begin
		if (hold_go && !hold_done) begin
			result_ready <= 1'b0;
			if (hold_count == HOLD_LEN)
				hold_done <= 1'b1;
			else
				hold_count <= hold_count + 1;
		end else begin
			result_ready <= arst_n && ($urandom_range(99) >= stall_pct);
		end
	end

	// Path building helpers
	task automatic add_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			path_buf.push_back(s[i]);
	endtask

	task automatic add_name(input int n);
		logic [7:0] b;
		int i;
		for (i = 0; i < n; i++) begin
			do
				b = 8'($urandom_range(255, 1));
			while (b == pcan_pkg::CHAR_SLASH);
			path_buf.push_back(b);
		end
	endtask

	task automatic add_slashes(input bit multi);
		if (multi && $urandom_range(3) == 0)
			repeat ($urandom_range(3, 2)) path_buf.push_back(pcan_pkg::CHAR_SLASH);
		else
			path_buf.push_back(pcan_pkg::CHAR_SLASH);
	endtask

	// "." and ".." make up 35 percent of components; dotted names like "..." or ".x" must be kept
	task automatic add_component(input bit dots, input int max_name);
		int r;
		r = $urandom_range(99);
		if (dots && r < 15) begin
			path_buf.push_back(pcan_pkg::CHAR_DOT);
		end else if (dots && r < 35) begin
			path_buf.push_back(pcan_pkg::CHAR_DOT);
			path_buf.push_back(pcan_pkg::CHAR_DOT);
		end else if (dots && r < 45) begin
			repeat ($urandom_range(3, 1)) path_buf.push_back(pcan_pkg::CHAR_DOT);
			add_name($urandom_range(2, 0));
		end else begin
			add_name($urandom_range(max_name, 1));
		end
	endtask

	task automatic flush_path;
		pcan_pkg::in_t it;
		int i;
		for (i = 0; i < path_buf.size(); i++) begin
			it.path_byte = path_buf[i];
			it.final_byte = (i == path_buf.size() - 1);
			pending_items.push_back(it);
			items_queued++;
		end
		path_buf.delete();
	endtask

	task automatic queue_short_path;
		int n;
		int i;
		if ($urandom_range(9) == 0) begin
			// noise, NUL bytes included
			repeat ($urandom_range(12, 1)) path_buf.push_back(8'($urandom_range(255, 0)));
		end else begin
			if ($urandom_range(1))
				add_slashes(1'b1);
			n = $urandom_range(5, 1);
			for (i = 0; i < n; i++) begin
				add_component(1'b1, 8);
				if (i < n - 1 || $urandom_range(3) == 0)
					add_slashes(1'b1);
			end
		end
		flush_path();
	endtask

	// Long path of at least min_bytes bytes; lead slash, dots and slash runs are optional
	task automatic queue_long_path(input bit lead, input bit dots, input int min_bytes);
		if (lead)
			path_buf.push_back(pcan_pkg::CHAR_SLASH);
		while (path_buf.size() < min_bytes) begin
			add_component(dots, 20);
			add_slashes(dots);
		end
		add_component(dots, 20);
		flush_path();
	endtask

	task automatic queue_phase(input int budget);
		int unsigned start;
		start = items_queued;
		while (items_queued - start < budget)
			queue_short_path();
	endtask

	task automatic wait_drained;
		do
			@(negedge clk);
		while (pending_items.size() != 0 || item_valid || expected_words.size() != 0);
	endtask

	// Run sequence
	initial begin
		path_restart();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: root, dot and dot-dot at root, slash runs, byte extremes, NUL
		add_text("/");
		flush_path();
		add_text("/./../");
		flush_path();
		add_text("a//b/..");
		flush_path();
		path_buf = '{8'hFF, pcan_pkg::CHAR_SLASH, 8'h01, 8'h00};
		add_text("...");
		flush_path();
		add_text("ab");
		path_buf.push_back(8'h00);
		flush_path();
		wait_drained();

		// no idling
		queue_phase(PHASE_ITEMS);
		wait_drained();

		// sender idle; one path that runs the buffer out
		idle_pct = 48;
		queue_long_path(1'b0, 1'b0, 128);
		queue_phase(PHASE_ITEMS);
		wait_drained();

		// receiver stalling; one dot-heavy path past the join limit
		idle_pct = 0;
		stall_pct = 48;
		queue_long_path(1'b1, 1'b1, 128);
		queue_phase(PHASE_ITEMS);
		wait_drained();

		// both idle a little; one path close to sixteen words
		idle_pct = 8;
		stall_pct = 8;
		queue_long_path(1'b1, 1'b0, 124);
		while (pending_items.size() > 0 && !pending_items[$].final_byte)
			void'(pending_items.pop_back());
		while (pending_items.size() > 124)
			void'(pending_items.pop_back());
		pending_items[$].final_byte = 1'b1;
		queue_phase(PHASE_ITEMS);
		wait_drained();

		// long receiver hold-off while the sender keeps pushing
		idle_pct = 0;
		stall_pct = 0;
		hold_go = 1'b1;
		queue_phase(5 * PHASE_ITEMS);
		wait_drained();

		repeat (DRAIN_WAIT) @(posedge clk);
		$display("tb: %0d items in %0d paths, %0d words checked, %0d overflow results",
			items_queued, paths_done, words_checked, error_results);
		$display("tb: %0d dot-dot components, %0d bytes past the join limit, %0d mismatches",
			rollbacks, past_join, mismatches);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// Watchdog
	initial begin
		#3_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule
